// ----- hdl/harf_pkg.sv -----
// ----------------------------------------------------------------------------
// harf_pkg
// shared types, character codes and helpers for the hex request framer
// ----------------------------------------------------------------------------
`default_nettype none

package harf_pkg;

  localparam logic [7:0] CHAR_SOH = 8'h01;
  localparam logic [7:0] CHAR_STX = 8'h02;
  localparam logic [7:0] CHAR_ETX = 8'h03;

  localparam logic [1:0] SIZE_NONE   = 2'd0;
  localparam logic [1:0] SIZE_16     = 2'd1;
  localparam logic [1:0] SIZE_32     = 2'd2;
  localparam logic [1:0] SIZE_16_32  = 2'd3;

  // fixed frame positions
  localparam logic [4:0] POS_SOH     = 5'd0;
  localparam logic [4:0] POS_STATION = 5'd1;
  localparam logic [4:0] POS_CMD_HI  = 5'd2;
  localparam logic [4:0] POS_CMD_LO  = 5'd3;
  localparam logic [4:0] POS_STX     = 5'd4;
  localparam logic [4:0] POS_DN_HI   = 5'd5;
  localparam logic [4:0] POS_DN_LO   = 5'd6;
  localparam logic [4:0] POS_PAYLOAD = 5'd7;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + ext) : (8'h37 + ext);
  endfunction

  function automatic logic [3:0] payload_chars(input logic [1:0] size);
    logic [3:0] n;
    case (size)
      SIZE_NONE: n = 4'd0;
      SIZE_16:   n = 4'd4;
      SIZE_32:   n = 4'd8;
      default:   n = 4'd12;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/harf_if.sv -----
// ----------------------------------------------------------------------------
// harf_if
// request and frame byte channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface harf_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  station;
  logic [7:0]  command;
  logic [7:0]  data_number;
  logic [1:0]  payload_size;
  logic [15:0] prefix_word;
  logic [31:0] data_word;

  modport source (output valid, station, command, data_number, payload_size,
                  prefix_word, data_word, input ready);
  modport sink (input valid, station, command, data_number, payload_size,
                prefix_word, data_word, output ready);
endinterface

interface harf_frm_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/harf_ctrl.sv -----
// ----------------------------------------------------------------------------
// harf_ctrl
// frame sequencer: takes a request, then steps the datapath byte by byte
// ----------------------------------------------------------------------------
`default_nettype none

module harf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output harf_pkg::dp_cmd_t      cmd,
  input  wire harf_pkg::dp_sts_t sts
);

  harf_pkg::state_t state_r;
  harf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= harf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      harf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = harf_pkg::ST_SEND;
        end
      end
      harf_pkg::ST_SEND: begin
        if (out_ready && sts.last) begin
          state_nxt = harf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = harf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      harf_pkg::ST_IDLE: in_ready  = 1'b1;
      harf_pkg::ST_SEND: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.load = in_valid && in_ready;
    cmd.step = out_valid && out_ready;
  end

endmodule

`default_nettype wire

// ----- hdl/harf_dp.sv -----
// ----------------------------------------------------------------------------
// harf_dp
// request hold registers, byte position, running checksum and byte select
// ----------------------------------------------------------------------------
`default_nettype none

module harf_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire harf_pkg::dp_cmd_t cmd,
  output harf_pkg::dp_sts_t      sts,
  input  wire logic [3:0]        station,
  input  wire logic [7:0]        command,
  input  wire logic [7:0]        data_number,
  input  wire logic [1:0]        payload_size,
  input  wire logic [15:0]       prefix_word,
  input  wire logic [31:0]       data_word,
  output logic [7:0]             frame_byte,
  output logic                   last_byte
);

  logic [3:0]  station_r;
  logic [7:0]  command_r;
  logic [7:0]  data_number_r;
  logic [1:0]  size_r;
  logic [47:0] payload_r;
  logic [47:0] payload_nxt;
  logic [4:0]  pos_r;
  logic [7:0]  sum_r;

  logic [4:0]  etx_pos;
  logic [3:0]  chr_idx;
  logic [47:0] payload_sh;
  logic        in_sum;

  // payload left aligned so the first character is always the top nibble
  always_comb begin
    case (payload_size)
      harf_pkg::SIZE_16:    payload_nxt = {data_word[15:0], 32'h0};
      harf_pkg::SIZE_32:    payload_nxt = {data_word, 16'h0};
      harf_pkg::SIZE_16_32: payload_nxt = {prefix_word, data_word};
      default:              payload_nxt = 48'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      station_r     <= station;
      command_r     <= command;
      data_number_r <= data_number;
      size_r        <= payload_size;
      payload_r     <= payload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
      sum_r <= 8'd0;
    end else if (cmd.load) begin
      pos_r <= 5'd0;
      sum_r <= 8'd0;
    end else if (cmd.step) begin
      pos_r <= pos_r + 5'd1;
      if (in_sum) begin
        sum_r <= sum_r + frame_byte;
      end
    end
  end

  always_comb begin
    etx_pos    = harf_pkg::POS_PAYLOAD + {1'b0, harf_pkg::payload_chars(size_r)};
    chr_idx    = 4'(pos_r - harf_pkg::POS_PAYLOAD);
    payload_sh = payload_r << {chr_idx, 2'b00};
    in_sum     = (pos_r != harf_pkg::POS_SOH) && (pos_r <= etx_pos);

    if (pos_r == harf_pkg::POS_SOH) begin
      frame_byte = harf_pkg::CHAR_SOH;
    end else if (pos_r == harf_pkg::POS_STATION) begin
      frame_byte = harf_pkg::hex_ascii(station_r);
    end else if (pos_r == harf_pkg::POS_CMD_HI) begin
      frame_byte = harf_pkg::hex_ascii(command_r[7:4]);
    end else if (pos_r == harf_pkg::POS_CMD_LO) begin
      frame_byte = harf_pkg::hex_ascii(command_r[3:0]);
    end else if (pos_r == harf_pkg::POS_STX) begin
      frame_byte = harf_pkg::CHAR_STX;
    end else if (pos_r == harf_pkg::POS_DN_HI) begin
      frame_byte = harf_pkg::hex_ascii(data_number_r[7:4]);
    end else if (pos_r == harf_pkg::POS_DN_LO) begin
      frame_byte = harf_pkg::hex_ascii(data_number_r[3:0]);
    end else if (pos_r < etx_pos) begin
      frame_byte = harf_pkg::hex_ascii(payload_sh[47:44]);
    end else if (pos_r == etx_pos) begin
      frame_byte = harf_pkg::CHAR_ETX;
    end else if (pos_r == etx_pos + 5'd1) begin
      frame_byte = harf_pkg::hex_ascii(sum_r[7:4]);
    end else begin
      frame_byte = harf_pkg::hex_ascii(sum_r[3:0]);
    end

    last_byte = (pos_r == etx_pos + 5'd2);
    sts.last  = last_byte;
  end

endmodule

`default_nettype wire

// ----- hdl/hex_ascii_request_framer.sv -----
// ----------------------------------------------------------------------------
// hex_ascii_request_framer
// frames a request as SOH, hex fields, STX/ETX and a two-character sum8
// the first frame byte is offered in the cycle after the request transaction
// throughput: one byte per cycle while out_frm.ready is high, 10/14/18/22 bytes
// per frame by payload size; a new request is taken the cycle after the last byte
// reset: synchronous active low, returns to idle with position and sum cleared
// ----------------------------------------------------------------------------
`default_nettype none

module hex_ascii_request_framer (
  input  wire logic clk,
  input  wire logic rst_n,
  harf_req_if.sink  in_req,
  harf_frm_if.source out_frm
);

  harf_pkg::dp_cmd_t cmd;
  harf_pkg::dp_sts_t sts;

  harf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_frm.valid),
    .out_ready (out_frm.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  harf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .station      (in_req.station),
    .command      (in_req.command),
    .data_number  (in_req.data_number),
    .payload_size (in_req.payload_size),
    .prefix_word  (in_req.prefix_word),
    .data_word    (in_req.data_word),
    .frame_byte   (out_frm.frame_byte),
    .last_byte    (out_frm.last_byte)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_req.ready && out_frm.valid))
    else $error("request taken while a frame is in flight");

  a_starts_soh: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=>
      (out_frm.valid && out_frm.frame_byte == harf_pkg::CHAR_SOH))
    else $error("frame does not open with SOH");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_frm.valid && out_frm.ready && out_frm.last_byte) |=>
      (in_req.ready && !out_frm.valid))
    else $error("frame did not end after last byte");

  a_step_not_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step in the same cycle");

endmodule

`default_nettype wire
